// ===== rtl/shst_pkg.sv =====
// Shared types, constants and saturating Q16.16 arithmetic for the source-term pipeline.
package shst_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS = 32;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;
	localparam logic signed [19:0] Q_HALF_PI = 20'sd102944;
	localparam logic [17:0] Q_PI = 18'd205887;
	localparam logic signed [19:0] CORDIC_GAIN_INV = 20'sd39797;
	localparam logic [18:0] GAMMA_ONE = 19'd65536;
	localparam logic [18:0] GAMMA_MIN = 19'd65537;

	localparam logic [1:0] REG_DIMS = 2'd0;
	localparam logic [1:0] REG_GAMMA = 2'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [31:0] v;
		logic sat;
	} qres_t;

	// everything that rides along the pipeline with one cell
	typedef struct packed {
		logic signed [31:0] n;
		logic signed [31:0] p;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic signed [31:0] w;
		logic [30:0] r;
		logic [18:0] gm1;
		logic dims1;
		logic err;
		logic sat;
		logic signed [31:0] pg;
		logic signed [31:0] nct;
		logic signed [31:0] uu;
		logic signed [31:0] vv;
		logic signed [31:0] ww;
		logic signed [31:0] nu;
		logic signed [31:0] a;
		logic signed [31:0] ke;
		logic signed [31:0] na;
		logic signed [31:0] nuu;
		logic signed [31:0] nuv;
		logic signed [31:0] nuw;
		logic signed [31:0] nua;
		logic signed [31:0] wpv;
		logic signed [31:0] wmv;
		logic signed [31:0] nke;
		logic signed [31:0] nw2;
		logic signed [31:0] t3a;
		logic signed [31:0] naw;
		logic signed [31:0] h;
		logic signed [31:0] t2;
		logic signed [31:0] t3;
		logic signed [31:0] t4;
		logic signed [31:0] d0;
		logic signed [31:0] ha;
		logic signed [31:0] hu;
		logic signed [31:0] d1;
		logic signed [31:0] q0;
		logic signed [31:0] q1;
		logic signed [31:0] q2;
		logic signed [31:0] q3;
		logic signed [31:0] q4;
	} carry_t;

	typedef struct packed {
		logic signed [31:0] src_density;
		logic signed [31:0] src_energy;
		logic signed [31:0] src_mom_radial;
		logic signed [31:0] src_mom_polar;
		logic signed [31:0] src_mom_azimuthal;
		logic [1:0] status;
	} res_t;

	function automatic logic signed [19:0] cordic_atan(input int i);
		case (i)
			0: cordic_atan = 20'sd51472;
			1: cordic_atan = 20'sd30386;
			2: cordic_atan = 20'sd16055;
			3: cordic_atan = 20'sd8150;
			4: cordic_atan = 20'sd4091;
			5: cordic_atan = 20'sd2047;
			6: cordic_atan = 20'sd1024;
			7: cordic_atan = 20'sd512;
			8: cordic_atan = 20'sd256;
			9: cordic_atan = 20'sd128;
			10: cordic_atan = 20'sd64;
			11: cordic_atan = 20'sd32;
			12: cordic_atan = 20'sd16;
			13: cordic_atan = 20'sd8;
			14: cordic_atan = 20'sd4;
			15: cordic_atan = 20'sd2;
			default: cordic_atan = 20'sd0;
		endcase
	endfunction

	function automatic qres_t sat66(input logic signed [65:0] x);
		qres_t r;
		if (x > 66'sd2147483647) begin
			r.v = 32'sh7fffffff;
			r.sat = 1'b1;
		end else if (x < -66'sd2147483648) begin
			r.v = 32'sh80000000;
			r.sat = 1'b1;
		end else begin
			r.v = x[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// product shifted right by 16, rounded toward minus infinity
	function automatic qres_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [63:0] prod;
		logic signed [65:0] x;
		prod = a * b;
		x = prod;
		x = x >>> 16;
		return sat66(x);
	endfunction

	function automatic qres_t qadd(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [65:0] x;
		logic signed [65:0] y;
		x = a;
		y = b;
		return sat66(x + y);
	endfunction

	function automatic qres_t qsub(input logic signed [31:0] a, input logic signed [31:0] b);
		logic signed [65:0] x;
		logic signed [65:0] y;
		x = a;
		y = b;
		return sat66(x - y);
	endfunction

	function automatic qres_t qneg(input logic signed [31:0] a);
		logic signed [65:0] x;
		x = a;
		return sat66(-x);
	endfunction

	function automatic qres_t qdbl(input logic signed [31:0] a);
		logic signed [65:0] x;
		x = a;
		return sat66(x <<< 1);
	endfunction

	function automatic qres_t qtrip(input logic signed [31:0] a);
		logic signed [65:0] x;
		x = a;
		return sat66(x + (x <<< 1));
	endfunction

endpackage

// ===== rtl/spherical_hydro_source_terms.sv =====
// Spherical Euler geometric and point-mass gravity source terms, one cell per transfer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data (dims, gamma)
//  in      | in        | in_valid / in_ready    | density, pressure, velocities, radius, angle
//  out     | out       | out_valid / out_ready  | five source terms, status
//
// One cell enters per clock while in_ready is high; out_valid rises once the input
// transfer has passed the input register, 17 CORDIC stages, three 34-stage divider chains
// (cot and p/(gamma-1), then /r, then a second /r), seven multiply/add stages and the
// output queue write. The divider chains set the latency.
// Reset clears valid bits and the output queue and sets the registers to dims 3, gamma 109227.
// The whole pipeline holds while the two-entry output queue is full; in_ready drops then.
module spherical_hydro_source_terms
	import shst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [18:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [30:0] density,
	input logic [30:0] pressure,
	input logic signed [31:0] vel_radial,
	input logic signed [31:0] vel_polar,
	input logic signed [31:0] vel_azimuthal,
	input logic [30:0] radius,
	input logic [17:0] polar_angle,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] src_density,
	output logic signed [31:0] src_energy,
	output logic signed [31:0] src_mom_radial,
	output logic signed [31:0] src_mom_polar,
	output logic signed [31:0] src_mom_azimuthal,
	output logic [1:0] status
);

	localparam int CW = $bits(carry_t);

	logic [1:0] dims_q;
	logic [18:0] gamma_q;
	logic en;
	logic q_full;

	carry_t in_c, c_s1;
	logic signed [19:0] z_in, z_s1;
	logic v_s1;

	logic cord_vld;
	logic signed [19:0] cord_x, cord_y;
	carry_t cord_c, k1_c;
	logic signed [31:0] sn, cs;
	logic [1:0][31:0] d1_num, d1_den, d1_quo;
	logic d1_vld, d1_sat;
	carry_t d1_c;

	carry_t m1_n, m2_n, m3_n, m4_n, m5_n, m6_n;
	carry_t c_s2, c_s3, c_s4, c_s5, c_s6, c_s7;
	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [6:0][31:0] d2_num, d2_den, d2_quo;
	logic d2_vld, d2_sat;
	carry_t d2_c, k2_c;
	logic [1:0][31:0] d3_num, d3_den, d3_quo;
	logic d3_vld, d3_sat;
	carry_t d3_c;

	res_t f_n, f_s8, q_data;
	logic v_s8;

	assign cfg_ready = 1'b1;
	assign en = !q_full;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 2'd3;
			gamma_q <= 19'd109227;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DIMS: dims_q <= cfg_data[1:0];
				REG_GAMMA: gamma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage: operand selection, angle clamp, early error checks
	always_comb begin
		logic [17:0] th;
		th = (polar_angle > Q_PI) ? Q_PI : polar_angle;
		in_c = '0;
		in_c.n = {1'b0, density};
		in_c.p = {1'b0, pressure};
		in_c.u = vel_radial;
		in_c.v = (dims_q >= 2'd2) ? vel_polar : 32'sd0;
		in_c.w = (dims_q == 2'd3) ? vel_azimuthal : 32'sd0;
		in_c.r = radius;
		in_c.dims1 = dims_q <= 2'd1;
		in_c.gm1 = (gamma_q < GAMMA_MIN) ? 19'd1 : gamma_q - GAMMA_ONE;
		in_c.err = (radius == 31'd0) || (!in_c.dims1 && (th == 18'd0 || th == Q_PI));
		z_in = $signed({2'b00, th}) - Q_HALF_PI;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= d1_vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= in_c;
			z_s1 <= z_in;
			c_s2 <= m1_n;
			c_s3 <= m2_n;
			c_s4 <= m3_n;
			c_s5 <= m4_n;
			c_s6 <= m5_n;
			c_s7 <= m6_n;
			f_s8 <= f_n;
		end
	end

	shst_cordic #(.SIDE_W(CW)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s1),
		.z_in(z_s1),
		.side_in(c_s1),
		.out_valid(cord_vld),
		.x_out(cord_x),
		.y_out(cord_y),
		.side_out(cord_c)
	);

	// sin = x, cos = -y; dims 0 or 1 forces the equator
	always_comb begin
		k1_c = cord_c;
		if (cord_c.dims1) begin
			sn = Q_ONE;
			cs = 32'sd0;
		end else begin
			sn = 32'(cord_x);
			cs = -(32'(cord_y));
			if (sn <= 32'sd0) begin
				k1_c.err = 1'b1;
			end
		end
		d1_num[0] = cs;
		d1_den[0] = sn;
		d1_num[1] = cord_c.p;
		d1_den[1] = {13'd0, cord_c.gm1};
	end

	shst_div #(.LANES(2), .SIDE_W(CW)) u_div_cot (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(cord_vld),
		.num(d1_num),
		.den(d1_den),
		.side_in(k1_c),
		.out_valid(d1_vld),
		.quo(d1_quo),
		.sat(d1_sat),
		.side_out(d1_c)
	);

	always_comb begin
		qres_t uu, vv, ww, nu, a, nct;
		logic signed [31:0] ct;
		ct = d1_quo[0];
		uu = qmul(d1_c.u, d1_c.u);
		vv = qmul(d1_c.v, d1_c.v);
		ww = qmul(d1_c.w, d1_c.w);
		nu = qmul(d1_c.n, d1_c.u);
		a = qmul(d1_c.v, ct);
		nct = qmul(d1_c.n, ct);
		m1_n = d1_c;
		m1_n.pg = d1_quo[1];
		m1_n.uu = uu.v;
		m1_n.vv = vv.v;
		m1_n.ww = ww.v;
		m1_n.nu = nu.v;
		m1_n.a = a.v;
		m1_n.nct = nct.v;
		m1_n.sat = d1_c.sat | d1_sat | uu.sat | vv.sat | ww.sat | nu.sat | a.sat | nct.sat;
	end

	always_comb begin
		qres_t ke1, ke, na, nuu, nuv, nuw, nua, wpv, wmv;
		ke1 = qadd(c_s2.uu, c_s2.vv);
		ke = qadd(ke1.v, c_s2.ww);
		na = qmul(c_s2.n, c_s2.a);
		nuu = qmul(c_s2.nu, c_s2.u);
		nuv = qmul(c_s2.nu, c_s2.v);
		nuw = qmul(c_s2.nu, c_s2.w);
		nua = qmul(c_s2.nu, c_s2.a);
		wpv = qadd(c_s2.ww, c_s2.vv);
		wmv = qsub(c_s2.ww, c_s2.vv);
		m2_n = c_s2;
		m2_n.ke = ke.v;
		m2_n.na = na.v;
		m2_n.nuu = nuu.v;
		m2_n.nuv = nuv.v;
		m2_n.nuw = nuw.v;
		m2_n.nua = nua.v;
		m2_n.wpv = wpv.v;
		m2_n.wmv = wmv.v;
		m2_n.sat = c_s2.sat | ke1.sat | ke.sat | na.sat | nuu.sat | nuv.sat | nuw.sat
			| nua.sat | wpv.sat | wmv.sat;
	end

	always_comb begin
		qres_t nke, nw2, t3a, naw;
		nke = qmul(c_s3.n, c_s3.ke);
		nw2 = qmul(c_s3.n, c_s3.wpv);
		t3a = qmul(c_s3.nct, c_s3.wmv);
		naw = qmul(c_s3.na, c_s3.w);
		m3_n = c_s3;
		m3_n.nke = nke.v;
		m3_n.nw2 = nw2.v;
		m3_n.t3a = t3a.v;
		m3_n.naw = naw.v;
		m3_n.sat = c_s3.sat | nke.sat | nw2.sat | t3a.sat | naw.sat;
	end

	always_comb begin
		qres_t e, h, nuu2, t2a, t2, nuv3, t3, naw2, ng, nuw3, t4, nu2, d0;
		e = qadd(c_s4.nke >>> 1, c_s4.pg);
		h = qadd(c_s4.p, e.v);
		nuu2 = qdbl(c_s4.nuu);
		t2a = qsub(c_s4.nw2, nuu2.v);
		t2 = qsub(t2a.v, c_s4.nua);
		nuv3 = qtrip(c_s4.nuv);
		t3 = qsub(c_s4.t3a, nuv3.v);
		naw2 = qdbl(c_s4.naw);
		ng = qneg(naw2.v);
		nuw3 = qtrip(c_s4.nuw);
		t4 = qsub(ng.v, nuw3.v);
		nu2 = qdbl(c_s4.nu);
		d0 = qadd(c_s4.na, nu2.v);
		m4_n = c_s4;
		m4_n.h = h.v;
		m4_n.t2 = t2.v;
		m4_n.t3 = t3.v;
		m4_n.t4 = t4.v;
		m4_n.d0 = d0.v;
		m4_n.sat = c_s4.sat | e.sat | h.sat | nuu2.sat | t2a.sat | t2.sat | nuv3.sat
			| t3.sat | naw2.sat | ng.sat | nuw3.sat | t4.sat | nu2.sat | d0.sat;
	end

	always_comb begin
		qres_t ha, hu;
		ha = qmul(c_s5.h, c_s5.a);
		hu = qmul(c_s5.h, c_s5.u);
		m5_n = c_s5;
		m5_n.ha = ha.v;
		m5_n.hu = hu.v;
		m5_n.sat = c_s5.sat | ha.sat | hu.sat;
	end

	always_comb begin
		qres_t hu2, d1;
		hu2 = qdbl(c_s6.hu);
		d1 = qadd(c_s6.ha, hu2.v);
		m6_n = c_s6;
		m6_n.d1 = d1.v;
		m6_n.sat = c_s6.sat | hu2.sat | d1.sat;
	end

	always_comb begin
		d2_num[0] = c_s7.d0;
		d2_num[1] = c_s7.d1;
		d2_num[2] = c_s7.t2;
		d2_num[3] = c_s7.t3;
		d2_num[4] = c_s7.t4;
		d2_num[5] = c_s7.nu;
		d2_num[6] = c_s7.n;
		for (int l = 0; l < 7; l++) begin
			d2_den[l] = {1'b0, c_s7.r};
		end
	end

	shst_div #(.LANES(7), .SIDE_W(CW)) u_div_r1 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s7),
		.num(d2_num),
		.den(d2_den),
		.side_in(c_s7),
		.out_valid(d2_vld),
		.quo(d2_quo),
		.sat(d2_sat),
		.side_out(d2_c)
	);

	// (nu/r) and (n/r) go through a second division by r
	always_comb begin
		k2_c = d2_c;
		k2_c.q0 = d2_quo[0];
		k2_c.q1 = d2_quo[1];
		k2_c.q2 = d2_quo[2];
		k2_c.q3 = d2_quo[3];
		k2_c.q4 = d2_quo[4];
		k2_c.sat = d2_c.sat | d2_sat;
		d3_num[0] = d2_quo[5];
		d3_num[1] = d2_quo[6];
		d3_den[0] = {1'b0, d2_c.r};
		d3_den[1] = {1'b0, d2_c.r};
	end

	shst_div #(.LANES(2), .SIDE_W(CW)) u_div_r2 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(d2_vld),
		.num(d3_num),
		.den(d3_den),
		.side_in(k2_c),
		.out_valid(d3_vld),
		.quo(d3_quo),
		.sat(d3_sat),
		.side_out(d3_c)
	);

	always_comb begin
		qres_t r0, r1a, r1, r2;
		r0 = qneg(d3_c.q0);
		r1a = qneg(d3_c.q1);
		r1 = qsub(r1a.v, d3_quo[0]);
		r2 = qsub(d3_c.q2, d3_quo[1]);
		if (d3_c.err) begin
			f_n.src_density = 32'sd0;
			f_n.src_energy = 32'sd0;
			f_n.src_mom_radial = 32'sd0;
			f_n.src_mom_polar = 32'sd0;
			f_n.src_mom_azimuthal = 32'sd0;
			f_n.status = ST_DIVZERO;
		end else begin
			f_n.src_density = r0.v;
			f_n.src_energy = r1.v;
			f_n.src_mom_radial = r2.v;
			f_n.src_mom_polar = d3_c.q3;
			f_n.src_mom_azimuthal = d3_c.q4;
			f_n.status = (d3_c.sat | d3_sat | r0.sat | r1a.sat | r1.sat | r2.sat)
				? ST_SAT : ST_OK;
		end
	end

	shst_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(v_s8 && en),
		.push_data(f_s8),
		.full(q_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(q_data)
	);

	assign src_density = q_data.src_density;
	assign src_energy = q_data.src_energy;
	assign src_mom_radial = q_data.src_mom_radial;
	assign src_mom_polar = q_data.src_mom_polar;
	assign src_mom_azimuthal = q_data.src_mom_azimuthal;
	assign status = q_data.status;

endmodule

// ===== rtl/shst_cordic.sv =====
// Pipelined rotation CORDIC, one iteration per stage, with a side payload.
module shst_cordic
	import shst_pkg::*;
#(
	parameter int SIDE_W = 1
)
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [19:0] z_in,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic signed [19:0] x_out,
	output logic signed [19:0] y_out,
	output logic [SIDE_W-1:0] side_out
);

	logic signed [19:0] x_s [CORDIC_STEPS+1];
	logic signed [19:0] y_s [CORDIC_STEPS+1];
	logic signed [19:0] z_s [CORDIC_STEPS+1];
	logic [SIDE_W-1:0] side_s [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[CORDIC_STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_GAIN_INV;
			y_s[0] <= 20'sd0;
			z_s[0] <= z_in;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 20'sd0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - cordic_atan(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + cordic_atan(i);
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS];
	assign x_out = x_s[CORDIC_STEPS];
	assign y_out = y_s[CORDIC_STEPS];
	assign side_out = side_s[CORDIC_STEPS];

endmodule

// ===== rtl/shst_div.sv =====
// Pipelined saturating Q16.16 divider lanes, one quotient bit per stage, with a side payload.
module shst_div
	import shst_pkg::*;
#(
	parameter int LANES = 1,
	parameter int SIDE_W = 1
)
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [LANES-1:0][31:0] num,
	input logic [LANES-1:0][31:0] den,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [LANES-1:0][31:0] quo,
	output logic sat,
	output logic [SIDE_W-1:0] side_out
);

	logic [DIV_STEPS:0][LANES-1:0][31:0] rem_s;
	logic [DIV_STEPS:0][LANES-1:0][31:0] lo_s;
	logic [DIV_STEPS:0][LANES-1:0][31:0] q_s;
	logic [DIV_STEPS:0][LANES-1:0][31:0] den_s;
	logic [DIV_STEPS:0][LANES-1:0] neg_s;
	logic [DIV_STEPS:0][LANES-1:0] ovf_s;
	logic [DIV_STEPS:0][SIDE_W-1:0] side_s;
	logic [DIV_STEPS:0] vld_s;

	logic [LANES-1:0][31:0] mag;
	logic [LANES-1:0][31:0] rem0;
	logic [LANES-1:0][31:0] lo0;
	logic [LANES-1:0] ovf0;
	logic [LANES-1:0] neg0;

	logic [LANES-1:0][31:0] quo_n;
	logic sat_n;
	logic [LANES-1:0][31:0] quo_q;
	logic sat_q;
	logic [SIDE_W-1:0] side_q;
	logic out_vld_q;

	// dividend is |num| << 16; quotient fits 32 bits iff the top 16 bits stay below den
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			neg0[l] = num[l][31];
			mag[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
			rem0[l] = {16'd0, mag[l][31:16]};
			lo0[l] = {mag[l][15:0], 16'd0};
			ovf0[l] = rem0[l] >= den[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[DIV_STEPS-1:0], in_valid};
			out_vld_q <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem0;
			lo_s[0] <= lo0;
			q_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg0;
			ovf_s[0] <= ovf0;
			side_s[0] <= side_in;
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [LANES-1:0][31:0] rem_n;
		logic [LANES-1:0][31:0] q_n;
		logic [LANES-1:0][31:0] lo_n;

		always_comb begin
			logic [32:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_s[i][l], lo_s[i][l][31]} - {1'b0, den_s[i][l]};
				if (!trial[32]) begin
					rem_n[l] = trial[31:0];
					q_n[l] = {q_s[i][l][30:0], 1'b1};
				end else begin
					rem_n[l] = {rem_s[i][l][30:0], lo_s[i][l][31]};
					q_n[l] = {q_s[i][l][30:0], 1'b0};
				end
				lo_n[l] = {lo_s[i][l][30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_n;
				q_s[i+1] <= q_n;
				lo_s[i+1] <= lo_n;
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_comb begin
		logic [31:0] qm;
		sat_n = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			qm = q_s[DIV_STEPS][l];
			if (neg_s[DIV_STEPS][l]) begin
				if (ovf_s[DIV_STEPS][l] || qm > 32'h80000000) begin
					quo_n[l] = 32'h80000000;
					sat_n = 1'b1;
				end else begin
					quo_n[l] = ~qm + 32'd1;
				end
			end else begin
				if (ovf_s[DIV_STEPS][l] || qm[31]) begin
					quo_n[l] = 32'h7fffffff;
					sat_n = 1'b1;
				end else begin
					quo_n[l] = qm;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= quo_n;
			sat_q <= sat_n;
			side_q <= side_s[DIV_STEPS];
		end
	end

	assign out_valid = out_vld_q;
	assign quo = quo_q;
	assign sat = sat_q;
	assign side_out = side_q;

endmodule

// ===== rtl/shst_outq.sv =====
// Two-entry output queue that decouples the pipeline from the result consumer.
module shst_outq
	import shst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input res_t push_data,
	output logic full,
	output logic out_valid,
	input logic out_ready,
	output res_t out_data
);

	res_t mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic pop;

	assign out_valid = cnt_q != 2'd0;
	assign full = cnt_q == 2'd2;
	assign pop = out_valid && out_ready;
	assign out_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== test/tb_spherical_hydro_source_terms.sv =====
// Self-checking testbench for spherical_hydro_source_terms: directed table plus random cells.
module tb_spherical_hydro_source_terms;
	import shst_pkg::*;

	localparam int HOLD_CYCLES = 600;
	localparam int DRAIN_CYCLES = 160;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_SETTING = 175;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	typedef struct {
		logic [30:0] n;
		logic [30:0] p;
		logic [31:0] u;
		logic [31:0] v;
		logic [31:0] w;
		logic [30:0] r;
		logic [17:0] th;
		bit zero_err;
	} cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [18:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [30:0] density = '0;
	logic [30:0] pressure = '0;
	logic signed [31:0] vel_radial = '0;
	logic signed [31:0] vel_polar = '0;
	logic signed [31:0] vel_azimuthal = '0;
	logic [30:0] radius = '0;
	logic [17:0] polar_angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] src_density;
	logic signed [31:0] src_energy;
	logic signed [31:0] src_mom_radial;
	logic signed [31:0] src_mom_polar;
	logic signed [31:0] src_mom_azimuthal;
	logic [1:0] status;

	spherical_hydro_source_terms dut (.*);

	always #1 clk = ~clk;

	logic [1:0] dims_model = 2'd3;
	logic [18:0] gamma_model = 19'd109227;
	res_t pending_terms[$];
	cell_t directed_cells[$];
	bit sat_seen;
	int mismatches = 0;
	int cells_sent = 0;
	int terms_seen = 0;
	int settings_run = 1;
	bit hold_go = 1'b0;

	function automatic longint clip(longint x);
		if (x > QMAX) begin
			sat_seen = 1'b1;
			return QMAX;
		end
		if (x < QMIN) begin
			sat_seen = 1'b1;
			return QMIN;
		end
		return x;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return clip((a * b) >>> 16);
	endfunction

	function automatic longint fdiv(longint a, longint b);
		if (b == 0)
			return 0;
		return clip((a * 65536) / b);
	endfunction

	// source terms of one cell under the current dims/gamma
	function automatic res_t source_terms(cell_t c);
		longint n, p, u, v, w, r, th, sn, cs, x, y, z, nx, gm1;
		longint ke, e, h, ct, a, nu, na, t;
		longint atan_q[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		bit err;
		res_t q;
		n = c.n;
		p = c.p;
		u = longint'(signed'(c.u));
		v = 0;
		w = 0;
		r = c.r;
		th = c.th;
		err = 1'b0;
		sat_seen = 1'b0;
		if (dims_model >= 2)
			v = longint'(signed'(c.v));
		if (dims_model == 3)
			w = longint'(signed'(c.w));
		if (th > 205887)
			th = 205887;
		if (dims_model <= 1) begin
			sn = 65536;
			cs = 0;
		end else begin
			x = 39797;
			y = 0;
			z = th - 102944;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_q[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_q[i];
				end
				x = nx;
			end
			sn = x;
			cs = -y;
			if (th == 0 || th >= 205887 || sn <= 0)
				err = 1'b1;
		end
		if (r == 0)
			err = 1'b1;
		if (err) begin
			q = '0;
			q.status = ST_DIVZERO;
			return q;
		end
		gm1 = longint'(gamma_model) - 65536;
		if (gm1 < 1)
			gm1 = 1;
		ke = clip(clip(fmul(u, u) + fmul(v, v)) + fmul(w, w));
		e = clip((fmul(n, ke) >>> 1) + fdiv(p, gm1));
		h = clip(p + e);
		ct = fdiv(cs, sn);
		a = fmul(v, ct);
		nu = fmul(n, u);
		na = fmul(n, a);
		q.src_density = 32'(clip(-fdiv(clip(na + clip(nu * 2)), r)));
		q.src_energy = 32'(clip(clip(-fdiv(clip(fmul(h, a) + clip(fmul(h, u) * 2)), r))
			- fdiv(fdiv(nu, r), r)));
		t = clip(clip(fmul(n, clip(fmul(w, w) + fmul(v, v))) - clip(fmul(nu, u) * 2))
			- fmul(nu, a));
		q.src_mom_radial = 32'(clip(fdiv(t, r) - fdiv(fdiv(n, r), r)));
		t = clip(fmul(fmul(n, ct), clip(fmul(w, w) - fmul(v, v))) - clip(fmul(nu, v) * 3));
		q.src_mom_polar = 32'(fdiv(t, r));
		t = clip(clip(-clip(fmul(na, w) * 2)) - clip(fmul(nu, w) * 3));
		q.src_mom_azimuthal = 32'(fdiv(t, r));
		q.status = sat_seen ? ST_SAT : ST_OK;
		return q;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h (dims %0d gamma %0d)",
			what, got, want, dims_model, gamma_model);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			terms_seen++;
			if (pending_terms.size() == 0) begin
				report("unexpected transfer", 32'(status), 32'd0);
			end else begin
				want = pending_terms.pop_front();
				if (src_density !== want.src_density)
					report("src_density", src_density, want.src_density);
				if (src_energy !== want.src_energy)
					report("src_energy", src_energy, want.src_energy);
				if (src_mom_radial !== want.src_mom_radial)
					report("src_mom_radial", src_mom_radial, want.src_mom_radial);
				if (src_mom_polar !== want.src_mom_polar)
					report("src_mom_polar", src_mom_polar, want.src_mom_polar);
				if (src_mom_azimuthal !== want.src_mom_azimuthal)
					report("src_mom_azimuthal", src_mom_azimuthal, want.src_mom_azimuthal);
				if (status !== want.status)
					report("status", 32'(status), 32'(want.status));
			end
		end
	end

	// receiver: changing stall pattern, plus one long hold-off on request
	initial begin
		int hold_left, mode, span;
		hold_left = 0;
		mode = 0;
		span = 0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 80);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 4) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_cell(cell_t c);
		res_t want;
		@(negedge clk);
		density <= c.n;
		pressure <= c.p;
		vel_radial <= c.u;
		vel_polar <= c.v;
		vel_azimuthal <= c.w;
		radius <= c.r;
		polar_angle <= c.th;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		if (c.zero_err) begin
			want = '0;
			want.status = ST_DIVZERO;
		end else begin
			want = source_terms(c);
		end
		pending_terms.push_back(want);
		cells_sent++;
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain;
		pause_sender(1);
		while (pending_terms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [18:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_DIMS)
			dims_model = data[1:0];
		else if (idx == REG_GAMMA)
			gamma_model = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(logic [30:0] n, logic [30:0] p, logic [31:0] u, logic [31:0] v,
			logic [31:0] w, logic [30:0] r, logic [17:0] th, bit zero_err);
		cell_t c;
		c = '{n, p, u, v, w, r, th, zero_err};
		directed_cells.push_back(c);
	endtask

	function automatic logic [31:0] spread32();
		return $urandom >> $urandom_range(0, 31);
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int pick;
		c.n = 31'(spread32());
		c.p = 31'(spread32());
		c.u = ($urandom_range(0, 1) == 1) ? -spread32() : spread32();
		c.v = ($urandom_range(0, 1) == 1) ? -spread32() : spread32();
		c.w = ($urandom_range(0, 1) == 1) ? -spread32() : spread32();
		if ($urandom_range(0, 7) == 0)
			c.u = $urandom;
		c.r = ($urandom_range(0, 49) == 0) ? 31'd0 : 31'(spread32());
		pick = $urandom_range(0, 19);
		if (pick == 0)
			c.th = 18'($urandom);
		else if (pick == 1)
			c.th = $urandom_range(0, 3) == 0 ? 18'd0 : 18'($urandom_range(205880, 205890));
		else
			c.th = 18'($urandom_range(1, 205886));
		c.zero_err = 1'b0;
		return c;
	endfunction

	task automatic random_phase(int count, bit long_hold);
		int left, burst;
		bit held;
		left = count;
		held = 1'b0;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (long_hold && !held && left <= count / 2) begin
				hold_go = 1'b1;
				held = 1'b1;
			end
			while (burst > 0 && left > 0) begin
				send_cell(random_cell());
				burst--;
				left--;
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		// directed cells under reset settings: dims 3, gamma 5/3
		add_row(31'd65536, 31'd65536, 32'd65536, 32'd0, 32'd0, 31'd0, 18'd102944, 1'b1);
		add_row(31'd65536, 31'd65536, 32'd65536, 32'd0, 32'd0, 31'd65536, 18'd0, 1'b1);
		add_row(31'd65536, 31'd65536, 32'd65536, 32'd0, 32'd0, 31'd65536, 18'd205887, 1'b1);
		add_row(31'd65536, 31'd65536, 32'd65536, 32'd0, 32'd0, 31'd65536, 18'h3ffff, 1'b1);
		add_row('0, '0, '0, '0, '0, 31'd65536, 18'd102944, 1'b0);
		add_row('1, '1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'd1, 18'd1, 1'b0);
		add_row('1, '1, 32'h80000000, 32'h80000000, 32'h80000000, '1, 18'd205886, 1'b0);
		add_row(31'd65536, 31'd32768, 32'd13107, -32'sd6554, 32'd3277, 31'd131072, 18'd51472,
			1'b0);
		add_row(31'd196608, 31'd65536, -32'sd65536, 32'd65536, -32'sd65536, 31'd327680,
			18'd154416, 1'b0);
		add_row(31'd1, 31'd1, 32'd1, 32'hffffffff, 32'd1, 31'd1, 18'd102944, 1'b0);
		add_row(31'd655360, 31'd0, 32'd0, 32'd65536, 32'd0, 31'd65536, 18'd1, 1'b0);
		add_row(31'd65536, '1, 32'd0, 32'd0, 32'd0, '1, 18'd102943, 1'b0);
		add_row(31'd1000, 31'd2000, 32'd3000, 32'd4000, 32'd5000, 31'd6000, 18'd7000, 1'b0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_cells[i])
			send_cell(directed_cells[i]);
		drain();

		random_phase(ITEMS_PER_SETTING, 1'b1);
		drain();
		write_reg(REG_DIMS, 19'd1);
		random_phase(ITEMS_PER_SETTING, 1'b0);
		drain();
		write_reg(REG_DIMS, 19'd2);
		write_reg(REG_GAMMA, 19'd65537);
		random_phase(ITEMS_PER_SETTING / 2, 1'b0);
		// sender waits until every outstanding cell has come back
		pause_sender(1);
		while (pending_terms.size() != 0)
			@(posedge clk);
		random_phase(ITEMS_PER_SETTING / 2, 1'b0);
		drain();
		write_reg(REG_DIMS, 19'h7fffc);
		write_reg(REG_GAMMA, 19'd262144);
		random_phase(ITEMS_PER_SETTING, 1'b0);
		drain();
		write_reg(REG_DIMS, 19'd3);
		write_reg(REG_GAMMA, 19'd0);
		random_phase(ITEMS_PER_SETTING, 1'b0);
		drain();
		write_reg(2'd2, 19'h7ffff);
		write_reg(2'd3, 19'd0);
		write_reg(REG_GAMMA, 19'h7ffff);
		random_phase(ITEMS_PER_SETTING, 1'b1);
		drain();
		write_reg(REG_DIMS, 19'd3);
		write_reg(REG_GAMMA, 19'd109227);
		random_phase(ITEMS_PER_SETTING + 10, 1'b0);
		drain();

		$display("covered %0d cells, %0d results over dims 0..3 and gamma extremes",
			cells_sent, terms_seen);
		$display("directed edges, random stalls and a long output hold-off included");
		if (mismatches == 0 && pending_terms.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
